// ===== rtl/cffa_pkg.sv =====
// Shared constants, codes and record types of the contiguous first-fit allocator.
// Depends on nothing; every other file of the block but cffa_ram imports it.
package cffa_pkg;

    localparam int MEM_CELLS   = 64;
    localparam int TABLE_SLOTS = 16;
    localparam int KEY_W       = 16;
    localparam int CELL_W      = $clog2(MEM_CELLS);
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int LEN_W       = $clog2(MEM_CELLS + 1);
    localparam int SCAN_W      = (CELL_W > SLOT_W) ? CELL_W : SLOT_W;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_SHRINK  = 2'd2,
        OP_COMPACT = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NO_RUN  = 3'd1,
        ST_FULL    = 3'd2,
        ST_NO_KEY  = 3'd3,
        ST_BAD_LEN = 3'd4
    } status_t;

    typedef struct packed {
        logic [LEN_W-1:0] length;
        logic [KEY_W-1:0] key;
        op_t              op;
    } req_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot_index;
        logic [CELL_W-1:0] start_cell;
        status_t           status;
    } result_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [CELL_W-1:0] start;
        logic [LEN_W-1:0]  length;
    } entry_t;

    localparam int REQ_W      = $bits(req_t);
    localparam int RES_W      = $bits(result_t);
    localparam int S_TDATA_W  = ((REQ_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((RES_W + 7) / 8) * 8;

endpackage

// ===== rtl/contiguous_first_fit_allocator.sv =====
// Contiguous first-fit allocator over a 64-cell store and a 16-slot entry table.
// Requests enter on the s_ channel, one result per request leaves on the m_ channel.
// Each request carries an operation: allocate, free, shrink or compact.
// A request is taken when s_tvalid and s_tready are high at a rising edge of aclk.
// The block works on one request at a time; s_tready is low while it is busy.
// Allocate scans the cell map for a free run, then marks the cells of that run.
// Free and shrink scan the table slots for the key, then release cells.
// Compact scans every table slot, then rewrites every cell of the map.
// The cell map RAM is read or written one cell per cycle.
// Results pass through an output register, so a new request is taken while a result
// still waits; a stalled m_tready holds m_tvalid and m_tdata and, once the next
// result is ready, holds the sequencer too.
// After aresetn is released a clearing pass writes every cell of the map as free;
// s_tready stays low until it ends.
// Reset empties the table and drops any pending result.
module contiguous_first_fit_allocator (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // operation[1:0], file_key[17:2], length[24:18], zeros above.
    input  logic [cffa_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status[2:0], start_cell[8:3], slot_index[12:9], zeros above.
    output logic [cffa_pkg::M_TDATA_W-1:0] m_tdata
);
    import cffa_pkg::*;

    req_t    req;
    result_t res;
    result_t res_q_reg;
    logic    res_valid, res_ready;
    logic    m_tvalid_reg;

    assign req = req_t'(s_tdata[REQ_W-1:0]);

    cffa_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
        if (res_ready && res_valid) begin
            res_q_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(res_q_reg);

`ifndef ASSERT_OFF
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res_q_reg.status != ST_OK |->
            res_q_reg.start_cell == '0 && res_q_reg.slot_index == '0)
        else $error("failed request reports a nonzero start or slot");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while one is in progress");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> res_q_reg.status <= ST_BAD_LEN)
        else $error("status code out of range");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while output register was full");
`endif

endmodule

// ===== rtl/cffa_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Depends on nothing.
module cffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/cffa_ctrl.sv =====
// Sequencer of the allocator: owns the cell map RAM, the entry table RAM and the valid bits.
// Depends on cffa_pkg and cffa_ram.
module cffa_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              req_valid,
    output logic              req_ready,
    input  cffa_pkg::req_t    req,
    output logic              res_valid,
    input  logic              res_ready,
    output cffa_pkg::result_t res
);
    import cffa_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RUN, S_MARK, S_KEY, S_UNMARK, S_PACK, S_FILL, S_DONE
    } state_t;

    state_t              state_reg, state_next;
    op_t                 op_reg, op_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [SCAN_W-1:0]   scan_reg, scan_next;
    logic                rvld_reg, rvld_next;
    logic [SCAN_W-1:0]   ridx_reg, ridx_next;
    logic [LEN_W-1:0]    run_reg, run_next;
    logic [LEN_W-1:0]    cnt_reg, cnt_next;
    logic [LEN_W-1:0]    end_reg, end_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [CELL_W-1:0]   start_reg, start_next;
    entry_t              rec_reg, rec_next;
    logic                free_mode_reg, free_mode_next;
    logic [LEN_W-1:0]    fill_reg, fill_next;
    logic [SLOT_W-1:0]   dst_reg, dst_next;
    logic [TABLE_SLOTS-1:0] valid_reg, valid_next;
    result_t             res_reg, res_next;

    logic                cell_we, cell_wdata, cell_rdata;
    logic [CELL_W-1:0]   cell_waddr, cell_raddr;
    logic                ent_we;
    logic [SLOT_W-1:0]   ent_waddr, ent_raddr;
    entry_t              ent_wdata, ent_rdata;
    logic                free_any;
    logic [SLOT_W-1:0]   free_slot;
    logic [LEN_W-1:0]    run_n, at;
    logic [SLOT_W-1:0]   ridx_slot;

    cffa_ram #(.WIDTH(1), .DEPTH(MEM_CELLS)) u_cells (
        .aclk(aclk), .we(cell_we), .waddr(cell_waddr), .wdata(cell_wdata),
        .raddr(cell_raddr), .rdata(cell_rdata)
    );

    cffa_ram #(.WIDTH($bits(entry_t)), .DEPTH(TABLE_SLOTS)) u_entries (
        .aclk(aclk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
        .raddr(ent_raddr), .rdata(ent_rdata)
    );

    always_comb begin
        free_any  = 1'b0;
        free_slot = '0;
        for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_any  = 1'b1;
                free_slot = SLOT_W'(i);
            end
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;
    assign ridx_slot = ridx_reg[SLOT_W-1:0];
    assign run_n     = cell_rdata ? '0 : run_reg + LEN_W'(1);
    assign at        = LEN_W'(ridx_reg) + LEN_W'(1) - len_reg;

    // A pack writes each moved record only to a slot at or below the one it was read from,
    // so no record of the table is overwritten before it has been read.
    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        len_next       = len_reg;
        scan_next      = scan_reg;
        rvld_next      = 1'b0;
        ridx_next      = scan_reg;
        run_next       = run_reg;
        cnt_next       = cnt_reg;
        end_next       = end_reg;
        slot_next      = slot_reg;
        start_next     = start_reg;
        rec_next       = rec_reg;
        free_mode_next = free_mode_reg;
        fill_next      = fill_reg;
        dst_next       = dst_reg;
        valid_next     = valid_reg;
        res_next       = res_reg;
        cell_we        = 1'b0;
        cell_waddr     = cnt_reg[CELL_W-1:0];
        cell_wdata     = 1'b0;
        cell_raddr     = scan_reg[CELL_W-1:0];
        ent_we         = 1'b0;
        ent_waddr      = slot_reg;
        ent_wdata      = rec_reg;
        ent_raddr      = scan_reg[SLOT_W-1:0];

        case (state_reg)
            S_CLEAR: begin
                cell_we  = 1'b1;
                cnt_next = cnt_reg + LEN_W'(1);
                if (cnt_reg == LEN_W'(MEM_CELLS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (req_valid) begin
                    op_next   = req.op;
                    key_next  = req.key;
                    len_next  = req.length;
                    scan_next = '0;
                    run_next  = '0;
                    dst_next  = '0;
                    fill_next = '0;
                    case (req.op)
                        OP_ALLOC: begin
                            if (req.length == '0 || req.length > LEN_W'(MEM_CELLS)) begin
                                res_next   = '{slot_index: '0, start_cell: '0,
                                               status: ST_BAD_LEN};
                                state_next = S_DONE;
                            end else if (!free_any) begin
                                res_next   = '{slot_index: '0, start_cell: '0,
                                               status: ST_FULL};
                                state_next = S_DONE;
                            end else begin
                                slot_next  = free_slot;
                                state_next = S_RUN;
                            end
                        end
                        OP_FREE, OP_SHRINK: begin
                            state_next = S_KEY;
                        end
                        OP_COMPACT: begin
                            state_next = S_PACK;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RUN: begin
                rvld_next = 1'b1;
                scan_next = scan_reg + SCAN_W'(1);
                if (rvld_reg) begin
                    run_next = run_n;
                    if (run_n == len_reg) begin
                        rvld_next  = 1'b0;
                        cnt_next   = at;
                        end_next   = at + len_reg;
                        start_next = at[CELL_W-1:0];
                        state_next = S_MARK;
                    end else if (ridx_reg == SCAN_W'(MEM_CELLS - 1)) begin
                        rvld_next  = 1'b0;
                        res_next   = '{slot_index: '0, start_cell: '0, status: ST_NO_RUN};
                        state_next = S_DONE;
                    end
                end
            end
            S_MARK: begin
                cell_we    = 1'b1;
                cell_wdata = 1'b1;
                cnt_next   = cnt_reg + LEN_W'(1);
                if (cnt_reg + LEN_W'(1) == end_reg) begin
                    ent_we               = 1'b1;
                    ent_wdata            = '{key: key_reg, start: start_reg, length: len_reg};
                    valid_next[slot_reg] = 1'b1;
                    res_next   = '{slot_index: slot_reg, start_cell: start_reg, status: ST_OK};
                    state_next = S_DONE;
                end
            end
            S_KEY: begin
                rvld_next = 1'b1;
                scan_next = scan_reg + SCAN_W'(1);
                if (rvld_reg) begin
                    if (valid_reg[ridx_slot] && ent_rdata.key == key_reg) begin
                        rvld_next  = 1'b0;
                        rec_next   = ent_rdata;
                        slot_next  = ridx_slot;
                        start_next = ent_rdata.start;
                        if (op_reg == OP_FREE || len_reg == '0) begin
                            free_mode_next = 1'b1;
                            cnt_next       = LEN_W'(ent_rdata.start);
                            end_next       = LEN_W'(ent_rdata.start) + ent_rdata.length;
                            state_next     = S_UNMARK;
                        end else if (len_reg > ent_rdata.length) begin
                            res_next   = '{slot_index: '0, start_cell: '0,
                                           status: ST_BAD_LEN};
                            state_next = S_DONE;
                        end else if (len_reg == ent_rdata.length) begin
                            res_next   = '{slot_index: ridx_slot,
                                           start_cell: ent_rdata.start, status: ST_OK};
                            state_next = S_DONE;
                        end else begin
                            free_mode_next  = 1'b0;
                            cnt_next        = LEN_W'(ent_rdata.start) + len_reg;
                            end_next        = LEN_W'(ent_rdata.start) + ent_rdata.length;
                            rec_next.length = len_reg;
                            state_next      = S_UNMARK;
                        end
                    end else if (ridx_reg == SCAN_W'(TABLE_SLOTS - 1)) begin
                        rvld_next  = 1'b0;
                        res_next   = '{slot_index: '0, start_cell: '0, status: ST_NO_KEY};
                        state_next = S_DONE;
                    end
                end
            end
            S_UNMARK: begin
                cell_we  = 1'b1;
                cnt_next = cnt_reg + LEN_W'(1);
                if (cnt_reg + LEN_W'(1) == end_reg) begin
                    if (free_mode_reg) begin
                        valid_next[slot_reg] = 1'b0;
                    end else begin
                        ent_we = 1'b1;
                    end
                    res_next   = '{slot_index: slot_reg, start_cell: start_reg, status: ST_OK};
                    state_next = S_DONE;
                end
            end
            S_PACK: begin
                rvld_next = 1'b1;
                scan_next = scan_reg + SCAN_W'(1);
                if (rvld_reg) begin
                    if (valid_reg[ridx_slot]) begin
                        ent_we                = 1'b1;
                        ent_waddr             = dst_reg;
                        ent_wdata             = '{key: ent_rdata.key,
                                                  start: fill_reg[CELL_W-1:0],
                                                  length: ent_rdata.length};
                        valid_next[ridx_slot] = 1'b0;
                        valid_next[dst_reg]   = 1'b1;
                        dst_next              = dst_reg + SLOT_W'(1);
                        fill_next             = fill_reg + ent_rdata.length;
                    end
                    if (ridx_reg == SCAN_W'(TABLE_SLOTS - 1)) begin
                        rvld_next  = 1'b0;
                        cnt_next   = '0;
                        state_next = S_FILL;
                    end
                end
            end
            S_FILL: begin
                cell_we    = 1'b1;
                cell_wdata = (cnt_reg < fill_reg);
                cnt_next   = cnt_reg + LEN_W'(1);
                if (cnt_reg == LEN_W'(MEM_CELLS - 1)) begin
                    res_next   = '{slot_index: '0, start_cell: '0, status: ST_OK};
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            cnt_reg   <= '0;
            rvld_reg  <= 1'b0;
            valid_reg <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rvld_reg  <= rvld_next;
            valid_reg <= valid_next;
        end
        op_reg        <= op_next;
        key_reg       <= key_next;
        len_reg       <= len_next;
        scan_reg      <= scan_next;
        ridx_reg      <= ridx_next;
        run_reg       <= run_next;
        end_reg       <= end_next;
        slot_reg      <= slot_next;
        start_reg     <= start_next;
        rec_reg       <= rec_next;
        free_mode_reg <= free_mode_next;
        fill_reg      <= fill_next;
        dst_reg       <= dst_next;
        res_reg       <= res_next;
    end

endmodule

// ===== sim/contiguous_first_fit_allocator_tb.sv =====
// Self-checking testbench for the contiguous first-fit allocator.
// Drives allocate, free, shrink and compact requests and checks every result against
// a typed directed row or a predictor of cell map and entry table; needs cffa_pkg.
module contiguous_first_fit_allocator_tb;
    import cffa_pkg::*;

    localparam int LIMIT = 1000000;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    contiguous_first_fit_allocator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #1 aclk = ~aclk;

    typedef struct {
        op_t      op;
        int       key;
        int       len;
        bit       typed;
        status_t  st;
        int       start_at;
        int       slot;
    } row_t;

    bit      map_used [MEM_CELLS];
    bit      slot_live [TABLE_SLOTS];
    int      slot_key [TABLE_SLOTS];
    int      slot_start [TABLE_SLOTS];
    int      slot_len [TABLE_SLOTS];
    result_t pending_results [$];
    int      errors = 0;
    int      cycles = 0;
    bit      hold_off = 1'b0;
    bit      sending_done = 1'b0;

    function automatic result_t predict_request(op_t op, int key, int len);
        result_t r;
        int s;
        int run;
        int at;
        int dst;
        int nxt;
        r.status = ST_OK;
        r.start_cell = '0;
        r.slot_index = '0;
        if (op == OP_ALLOC) begin
            if (len == 0 || len > MEM_CELLS) begin
                r.status = ST_BAD_LEN;
            end else begin
                s = 0;
                while (s < TABLE_SLOTS && slot_live[s]) s++;
                if (s >= TABLE_SLOTS) begin
                    r.status = ST_FULL;
                end else begin
                    at = -1;
                    run = 0;
                    for (int c = 0; c < MEM_CELLS && at < 0; c++) begin
                        run = map_used[c] ? 0 : run + 1;
                        if (run == len) at = c + 1 - len;
                    end
                    if (at < 0) begin
                        r.status = ST_NO_RUN;
                    end else begin
                        for (int c = at; c < at + len; c++) map_used[c] = 1'b1;
                        slot_live[s] = 1'b1;
                        slot_key[s] = key;
                        slot_start[s] = at;
                        slot_len[s] = len;
                        r.start_cell = CELL_W'(at);
                        r.slot_index = SLOT_W'(s);
                    end
                end
            end
        end else if (op == OP_FREE || op == OP_SHRINK) begin
            s = 0;
            while (s < TABLE_SLOTS && !(slot_live[s] && slot_key[s] == key)) s++;
            if (s >= TABLE_SLOTS) begin
                r.status = ST_NO_KEY;
            end else if (op == OP_FREE || len == 0) begin
                for (int c = slot_start[s]; c < slot_start[s] + slot_len[s]; c++)
                    map_used[c] = 1'b0;
                slot_live[s] = 1'b0;
                r.start_cell = CELL_W'(slot_start[s]);
                r.slot_index = SLOT_W'(s);
            end else if (len > slot_len[s]) begin
                r.status = ST_BAD_LEN;
            end else begin
                for (int c = slot_start[s] + len; c < slot_start[s] + slot_len[s]; c++)
                    map_used[c] = 1'b0;
                slot_len[s] = len;
                r.start_cell = CELL_W'(slot_start[s]);
                r.slot_index = SLOT_W'(s);
            end
        end else begin
            dst = 0;
            nxt = 0;
            for (int c = 0; c < MEM_CELLS; c++) map_used[c] = 1'b0;
            for (s = 0; s < TABLE_SLOTS; s++) begin
                if (slot_live[s]) begin
                    slot_live[s] = 1'b0;
                    slot_live[dst] = 1'b1;
                    slot_key[dst] = slot_key[s];
                    slot_len[dst] = slot_len[s];
                    slot_start[dst] = nxt;
                    for (int c = nxt; c < nxt + slot_len[dst]; c++) map_used[c] = 1'b1;
                    nxt += slot_len[dst];
                    dst++;
                end
            end
        end
        return r;
    endfunction

    task automatic send_request(op_t op, int key, int len, bit typed, result_t want);
        req_t q;
        result_t p;
        q.op = op;
        q.key = KEY_W'(key);
        q.length = LEN_W'(len);
        p = predict_request(op, key, len);
        if (typed && p != want)
            $error("directed row disagrees: expected %h predicted %h", want, p);
        pending_results.push_back(typed ? want : p);
        s_tdata <= S_TDATA_W'(q);
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Random gaps between bursts of back-to-back requests.
    task automatic send_and_pace(op_t op, int key, int len, bit typed, result_t want,
                                 ref int burst);
        int gap;
        send_request(op, key, len, typed, want);
        if (burst > 0) begin
            burst--;
        end else begin
            gap = $urandom_range(0, 120);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst = $urandom_range(0, 8);
        end
    endtask

    function automatic int pick_key();
        int s;
        s = $urandom_range(0, TABLE_SLOTS - 1);
        if ($urandom_range(0, 9) < 8 && slot_live[s]) return slot_key[s];
        return $urandom_range(0, 9) < 7 ? $urandom_range(0, 15) : $urandom_range(0, 65535);
    endfunction

    row_t directed [$] = '{
        '{OP_FREE,    5,     0,   1, ST_NO_KEY,  0, 0},
        '{OP_ALLOC,   1,     0,   1, ST_BAD_LEN, 0, 0},
        '{OP_ALLOC,   1,     65,  1, ST_BAD_LEN, 0, 0},
        '{OP_ALLOC,   1,     127, 1, ST_BAD_LEN, 0, 0},
        '{OP_ALLOC,   65535, 64,  1, ST_OK,      0, 0},
        '{OP_ALLOC,   2,     1,   1, ST_NO_RUN,  0, 0},
        '{OP_SHRINK,  65535, 65,  1, ST_BAD_LEN, 0, 0},
        '{OP_SHRINK,  65535, 64,  1, ST_OK,      0, 0},
        '{OP_SHRINK,  65535, 10,  1, ST_OK,      0, 0},
        '{OP_ALLOC,   7,     3,   0, ST_OK,      0, 0},
        '{OP_ALLOC,   7,     5,   0, ST_OK,      0, 0},
        '{OP_FREE,    65535, 0,   1, ST_OK,      0, 0},
        '{OP_SHRINK,  7,     0,   0, ST_OK,      0, 0},
        '{OP_SHRINK,  7,     6,   1, ST_BAD_LEN, 0, 0},
        '{OP_ALLOC,   9,     2,   0, ST_OK,      0, 0},
        '{OP_COMPACT, 43690, 85,  1, ST_OK,      0, 0},
        '{OP_SHRINK,  1234,  3,   1, ST_NO_KEY,  0, 0},
        '{OP_COMPACT, 0,     0,   1, ST_OK,      0, 0}
    };

    initial begin
        int burst;
        result_t want;
        op_t op;
        int len;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        burst = 0;
        foreach (directed[i]) begin
            want.status = directed[i].st;
            want.start_cell = CELL_W'(directed[i].start_at);
            want.slot_index = SLOT_W'(directed[i].slot);
            send_and_pace(directed[i].op, directed[i].key, directed[i].len,
                          directed[i].typed, want, burst);
        end
        // Fill the table with small runs so that table-full or no-run results show up.
        for (int i = 0; i < TABLE_SLOTS + 1; i++)
            send_and_pace(OP_ALLOC, i, $urandom_range(1, 4), 1'b0, want, burst);
        send_and_pace(OP_ALLOC, 3, 60, 1'b0, want, burst);
        for (int i = 0; i < 620; i++) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7: op = OP_ALLOC;
                8, 9, 10, 11, 12:       op = OP_FREE;
                13, 14, 15, 16, 17:     op = OP_SHRINK;
                default:                op = OP_COMPACT;
            endcase
            case ($urandom_range(0, 9))
                0:       len = $urandom_range(0, 127);
                1:       len = $urandom_range(0, 64);
                2:       len = 0;
                default: len = $urandom_range(1, 8);
            endcase
            send_and_pace(op, pick_key(), len, 1'b0, want, burst);
        end
        s_tvalid <= 1'b0;
        sending_done <= 1'b1;
    end

    // Receiver: random stalls, plus one long hold-off while the sender keeps going.
    initial begin
        int hold_count;
        wait (aresetn);
        repeat (60) @(posedge aclk);
        hold_off <= 1'b1;
        hold_count = 0;
        while (hold_count < 600) begin
            @(posedge aclk);
            hold_count++;
        end
        hold_off <= 1'b0;
    end

    always @(posedge aclk) begin
        if (!aresetn || hold_off) begin
            m_tready <= 1'b0;
        end else if ((cycles / 500) % 3 == 0) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge aclk) begin
        result_t got;
        result_t exp_r;
        cycles <= cycles + 1;
        if (m_tvalid && m_tready) begin
            got = result_t'(m_tdata[RES_W-1:0]);
            if (pending_results.size() == 0) begin
                $error("result with none expected: %h", got);
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                if (got.status != exp_r.status) begin
                    $error("status: expected %0d actual %0d", exp_r.status, got.status);
                    errors++;
                end
                if (got.start_cell != exp_r.start_cell) begin
                    $error("start_cell: expected %0d actual %0d",
                           exp_r.start_cell, got.start_cell);
                    errors++;
                end
                if (got.slot_index != exp_r.slot_index) begin
                    $error("slot_index: expected %0d actual %0d",
                           exp_r.slot_index, got.slot_index);
                    errors++;
                end
            end
        end
    end

    initial begin
        wait (sending_done && pending_results.size() == 0);
        repeat (200) @(posedge aclk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        wait (cycles >= LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/cffa_pkg.sv
rtl/cffa_ram.sv
rtl/cffa_ctrl.sv
rtl/contiguous_first_fit_allocator.sv
sim/contiguous_first_fit_allocator_tb.sv
